[rtl/grid_line_of_sight_check_top_macros.svh]
// Assertion macros used by the line-of-sight walker module.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef GRID_LINE_OF_SIGHT_CHECK_TOP_MACROS_SVH
`define GRID_LINE_OF_SIGHT_CHECK_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GLOS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("glos assertion failed");
`define GLOS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("glos assertion failed");
`else
`define GLOS_ASSERT(lbl, cond)
`define GLOS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[rtl/glos_pkg.sv]
`timescale 1ns / 1ps

package glos_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned QDepth = 2;

  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A,
    ST_B,
    ST_ADV
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CELL,
    RD_FLANK1,
    RD_FLANK2
  } rd_kind_e;

  // A query is held in major/minor axis terms; swap means the major axis is y.
  typedef struct packed {
    logic   is_query;
    logic   wr_free;
    coord_t wr_x;
    coord_t wr_y;
    logic   swap;
    logic   neg_a;
    logic   neg_b;
    logic   zero_len;
    coord_t a0;
    coord_t b0;
    coord_t a_end;
    coord_t dmaj;
    coord_t dmin;
  } cmd_t;

endpackage

[rtl/glos_front.sv]
`timescale 1ns / 1ps

module glos_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              func_i,
  input  logic [7:0]        x_from_i,
  input  logic [7:0]        y_from_i,
  input  logic [7:0]        x_to_i,
  input  logic [7:0]        y_to_i,
  input  logic              cell_free_i,
  output logic              cmd_vld_o,
  output glos_pkg::cmd_t    cmd_o,
  input  logic              cmd_rdy_i
);

  logic           vld_q;
  glos_pkg::cmd_t cmd_q;
  glos_pkg::cmd_t cmd_d;
  logic           take;
  logic           x_up;
  logic           y_up;
  logic [7:0]     dx;
  logic [7:0]     dy;
  logic           swap;

  always_comb begin
    x_up = x_to_i > x_from_i;
    y_up = y_to_i > y_from_i;
    dx   = x_up ? (x_to_i - x_from_i) : (x_from_i - x_to_i);
    dy   = y_up ? (y_to_i - y_from_i) : (y_from_i - y_to_i);
    swap = dy > dx;

    cmd_d.is_query = (func_i == glos_pkg::FUNC_QUERY);
    cmd_d.wr_free  = cell_free_i;
    cmd_d.wr_x     = x_from_i;
    cmd_d.wr_y     = y_from_i;
    cmd_d.swap     = swap;
    cmd_d.neg_a    = swap ? !y_up : !x_up;
    cmd_d.neg_b    = swap ? !x_up : !y_up;
    cmd_d.a0       = swap ? y_from_i : x_from_i;
    cmd_d.b0       = swap ? x_from_i : y_from_i;
    cmd_d.a_end    = swap ? y_to_i : x_to_i;
    cmd_d.dmaj     = swap ? dy : dx;
    cmd_d.dmin     = swap ? dx : dy;
    cmd_d.zero_len = (cmd_d.dmaj == 8'd0);
  end

  assign full      = vld_q && !cmd_rdy_i;
  assign take      = push && !full;
  assign cmd_vld_o = vld_q;
  assign cmd_o     = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (cmd_rdy_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[rtl/glos_cmd_queue.sv]
`timescale 1ns / 1ps

module glos_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  glos_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output logic           empty_o,
  output glos_pkg::cmd_t rdata_o
);

  localparam int unsigned PtrW = $clog2(glos_pkg::QDepth);
  localparam int unsigned CntW = $clog2(glos_pkg::QDepth + 1);

  glos_pkg::cmd_t  ent_q [glos_pkg::QDepth];
  logic [PtrW-1:0] wptr_q;
  logic [PtrW-1:0] rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(glos_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(glos_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(glos_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/glos_walker.sv]
`timescale 1ns / 1ps
`include "grid_line_of_sight_check_top_macros.svh"

module glos_walker #(
  parameter int unsigned MAP_W = 256,
  parameter int unsigned MAP_H = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  glos_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic           line_clear_o,
  output logic           was_query_o
);

  // Only cells reachable by 8-bit coordinates are stored.
  localparam int unsigned Cols  = (MAP_W < 256) ? MAP_W : 256;
  localparam int unsigned Rows  = (MAP_H < 256) ? MAP_H : 256;
  localparam int unsigned Depth = Cols * Rows;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PtrW  = $clog2(glos_pkg::QDepth);
  localparam int unsigned CntW  = $clog2(glos_pkg::QDepth + 1);

  glos_pkg::state_e   state_q;
  glos_pkg::state_e   state_d;
  glos_pkg::cmd_t     cur_q;
  logic [7:0]         a_q;
  logic [7:0]         b_q;
  logic [7:0]         err_q;
  logic               fail_q;
  logic               fail_d;
  logic               flank_blk_q;
  glos_pkg::rd_kind_e rd_kind_q;
  glos_pkg::rd_kind_e issue_kind;
  logic               rd_ok_q;
  logic               rdata_q;
  logic [AW-1:0]      clr_q;

  logic               map_q [Depth];
  logic               mem_we;
  logic               mem_wd;
  logic [AW-1:0]      mem_addr;

  logic [8:0]         chk_a;
  logic [8:0]         chk_b;
  logic               sel_swap;
  logic [8:0]         cx;
  logic [8:0]         cy;
  logic               in_map;
  logic [AW-1:0]      cell_addr;

  logic [8:0]         en9;
  logic [8:0]         err_sub;
  logic               minor;
  logic [7:0]         a_next;
  logic               walk_done;
  logic               blocked;
  logic               start_query;

  logic [1:0]         res_q [glos_pkg::QDepth];
  logic [PtrW-1:0]    res_wptr_q;
  logic [PtrW-1:0]    res_rptr_q;
  logic [CntW-1:0]    res_cnt_q;
  logic               res_room;
  logic               res_push;
  logic [1:0]         res_in;
  logic               res_pop;

  assign en9       = {1'b0, err_q} + {1'b0, cur_q.dmin};
  assign err_sub   = en9 - {1'b0, cur_q.dmaj};
  assign minor     = (en9 >= {1'b0, cur_q.dmaj});
  assign a_next    = cur_q.neg_a ? (a_q - 8'd1) : (a_q + 8'd1);
  assign blocked   = !(rd_ok_q && rdata_q);
  assign fail_d    = fail_q
                   || ((rd_kind_q == glos_pkg::RD_CELL) && blocked)
                   || ((rd_kind_q == glos_pkg::RD_FLANK2) && blocked && flank_blk_q);
  assign walk_done = fail_d || (a_next == cur_q.a_end);
  assign res_room  = (res_cnt_q != CntW'(glos_pkg::QDepth));
  assign start_query = cmd_pop_o && cmd_i.is_query && !cmd_i.zero_len;

  // Cell selection for the read or write of this cycle.
  always_comb begin
    chk_a      = {1'b0, a_q};
    chk_b      = {1'b0, b_q};
    sel_swap   = cur_q.swap;
    issue_kind = glos_pkg::RD_NONE;
    case (state_q)
      glos_pkg::ST_IDLE: begin
        chk_a    = {1'b0, cmd_i.wr_x};
        chk_b    = {1'b0, cmd_i.wr_y};
        sel_swap = 1'b0;
      end
      glos_pkg::ST_A: begin
        chk_a = {1'b0, a_q} - {8'd0, cur_q.neg_a};
        if (minor) begin
          chk_b      = {1'b0, b_q} - {8'd0, cur_q.neg_b};
          issue_kind = glos_pkg::RD_CELL;
        end else if (cur_q.dmin == 8'd0) begin
          issue_kind = glos_pkg::RD_FLANK1;
        end
      end
      glos_pkg::ST_B: begin
        chk_a = {1'b0, a_q} - {8'd0, cur_q.neg_a};
        if (cur_q.dmin == 8'd0) begin
          chk_b      = {1'b0, b_q} - 9'd1;
          issue_kind = glos_pkg::RD_FLANK2;
        end else if (err_q != 8'd0) begin
          chk_b      = {1'b0, b_q} - {8'd0, cur_q.neg_b};
          issue_kind = glos_pkg::RD_CELL;
        end
      end
      default: begin
        issue_kind = glos_pkg::RD_NONE;
      end
    endcase
  end

  always_comb begin
    cx        = sel_swap ? chk_b : chk_a;
    cy        = sel_swap ? chk_a : chk_b;
    in_map    = !cx[8] && !cy[8]
              && ({1'b0, cx[7:0]} < 9'(Cols)) && ({1'b0, cy[7:0]} < 9'(Rows));
    cell_addr = AW'(cy[7:0] * Cols) + AW'(cx[7:0]);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      glos_pkg::ST_CLEAR: begin
        if (clr_q == AW'(Depth - 1)) begin
          state_d = glos_pkg::ST_IDLE;
        end
      end
      glos_pkg::ST_IDLE: begin
        if (start_query) begin
          state_d = glos_pkg::ST_A;
        end
      end
      glos_pkg::ST_A:   state_d = glos_pkg::ST_B;
      glos_pkg::ST_B:   state_d = glos_pkg::ST_ADV;
      glos_pkg::ST_ADV: begin
        state_d = walk_done ? glos_pkg::ST_IDLE : glos_pkg::ST_A;
      end
      default: state_d = glos_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_wd    = 1'b0;
    mem_addr  = cell_addr;
    res_push  = 1'b0;
    res_in    = 2'b00;
    case (state_q)
      glos_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      glos_pkg::ST_IDLE: begin
        if (!cmd_empty_i && res_room) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_query) begin
            mem_we   = in_map;
            mem_wd   = cmd_i.wr_free;
            res_push = 1'b1;
            res_in   = 2'b00;
          end else if (cmd_i.zero_len) begin
            res_push = 1'b1;
            res_in   = 2'b11;
          end
        end
      end
      glos_pkg::ST_ADV: begin
        if (walk_done) begin
          res_push = 1'b1;
          res_in   = {!fail_d, 1'b1};
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= glos_pkg::ST_CLEAR;
      clr_q     <= '0;
      rd_kind_q <= glos_pkg::RD_NONE;
    end else begin
      state_q   <= state_d;
      rd_kind_q <= issue_kind;
      if (state_q == glos_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= in_map;
    fail_q  <= start_query ? 1'b0 : fail_d;
    if (rd_kind_q == glos_pkg::RD_FLANK1) begin
      flank_blk_q <= blocked;
    end
    if (start_query) begin
      cur_q  <= cmd_i;
      a_q    <= cmd_i.a0;
      b_q    <= cmd_i.b0;
      err_q  <= 8'd0;
    end
    if (state_q == glos_pkg::ST_A) begin
      err_q <= minor ? err_sub[7:0] : en9[7:0];
      if (minor) begin
        b_q <= cur_q.neg_b ? (b_q - 8'd1) : (b_q + 8'd1);
      end
    end
    if (state_q == glos_pkg::ST_ADV) begin
      a_q <= a_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_q[mem_addr] <= mem_wd;
    end
    rdata_q <= map_q[mem_addr];
  end

  assign empty        = (res_cnt_q == '0);
  assign res_pop      = pop && !empty;
  assign line_clear_o = res_q[res_rptr_q][1];
  assign was_query_o  = res_q[res_rptr_q][0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      if (res_push) begin
        res_wptr_q <= (res_wptr_q == PtrW'(glos_pkg::QDepth - 1)) ? '0 : res_wptr_q + 1'b1;
      end
      if (res_pop) begin
        res_rptr_q <= (res_rptr_q == PtrW'(glos_pkg::QDepth - 1)) ? '0 : res_rptr_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wptr_q] <= res_in;
    end
  end

  `GLOS_ASSERT(a_res_cnt_range, res_cnt_q <= CntW'(glos_pkg::QDepth))
  `GLOS_ASSERT(a_no_push_full, !(res_push && !res_room))
  `GLOS_ASSERT(a_no_pop_clear, !((state_q == glos_pkg::ST_CLEAR) && cmd_pop_o))
  `GLOS_ASSERT_NEXT(a_flank_pair, rd_kind_q == glos_pkg::RD_FLANK1, rd_kind_q == glos_pkg::RD_FLANK2)
  `GLOS_ASSERT_NEXT(a_done_idle, (state_q == glos_pkg::ST_ADV) && res_push, state_q == glos_pkg::ST_IDLE)

endmodule

[rtl/grid_line_of_sight_check_top.sv]
`timescale 1ns / 1ps
// Channel   Handshake            Words
// input     push / full          func, x_from, y_from, x_to, y_to, cell_free
// result    empty / pop          line_clear, was_query
//
// A write is taken in ST_IDLE in the walker; a query walks ST_A, ST_B and ST_ADV once for
// each of the N major-axis steps walked, each step making up to two map reads.
// After reset the walker clears all min(MAP_W, 256) * min(MAP_H, 256) cells of the map,
// one cell a cycle, and takes no word from its queue until then.
// The front and a two-word command queue keep accepting words while the walker is busy;
// a two-word result queue lets the walker finish while results wait to be popped.
module grid_line_of_sight_check_top #(
  parameter int unsigned MAP_W = 256,
  parameter int unsigned MAP_H = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       func_i,
  input  logic [7:0] x_from_i,
  input  logic [7:0] y_from_i,
  input  logic [7:0] x_to_i,
  input  logic [7:0] y_to_i,
  input  logic       cell_free_i,
  output logic       empty,
  input  logic       pop,
  output logic       line_clear_o,
  output logic       was_query_o
);

  logic           fr_vld;
  glos_pkg::cmd_t fr_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  glos_pkg::cmd_t q_cmd;

  glos_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .x_from_i    (x_from_i),
    .y_from_i    (y_from_i),
    .x_to_i      (x_to_i),
    .y_to_i      (y_to_i),
    .cell_free_i (cell_free_i),
    .cmd_vld_o   (fr_vld),
    .cmd_o       (fr_cmd),
    .cmd_rdy_i   (!q_full)
  );

  glos_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_vld),
    .full_o  (q_full),
    .wdata_i (fr_cmd),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_cmd)
  );

  glos_walker #(
    .MAP_W (MAP_W),
    .MAP_H (MAP_H)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (q_empty),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .empty        (empty),
    .pop          (pop),
    .line_clear_o (line_clear_o),
    .was_query_o  (was_query_o)
  );

endmodule

[tb/glos_sight_checker.sv]
`timescale 1ns / 1ps

module glos_sight_checker #(
  parameter int MapW = 256,
  parameter int MapH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        func_i,
  input  logic [7:0]  x_from_i,
  input  logic [7:0]  y_from_i,
  input  logic [7:0]  x_to_i,
  input  logic [7:0]  y_to_i,
  input  logic        cell_free_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        line_clear_i,
  input  logic        was_query_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic line_clear;
    logic was_query;
  } answer_t;

  bit          cell_map [MapW * MapH];
  answer_t     awaited_answers [$];
  int unsigned mismatches;

  function automatic bit cell_open(int x, int y);
    if (x < 0 || y < 0 || x >= MapW || y >= MapH) return 1'b0;
    return cell_map[y * MapW + x];
  endfunction

  function automatic bit line_unblocked(int x0, int y0, int x1, int y1);
    int dx, dy, sx, sy, ox, oy, cx, cy, err;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx  = (x1 > x0) ? 1 : -1;
    sy  = (y1 > y0) ? 1 : -1;
    ox  = (sx > 0) ? 0 : -1;
    oy  = (sy > 0) ? 0 : -1;
    cx  = x0;
    cy  = y0;
    err = 0;
    if (dx >= dy) begin
      while (cx != x1) begin
        err += dy;
        if (err >= dx) begin
          if (!cell_open(cx + ox, cy + oy)) return 1'b0;
          cy  += sy;
          err -= dx;
        end
        if (err != 0 && !cell_open(cx + ox, cy + oy)) return 1'b0;
        if (dy == 0 && !cell_open(cx + ox, cy) && !cell_open(cx + ox, cy - 1)) return 1'b0;
        cx += sx;
      end
    end else begin
      while (cy != y1) begin
        err += dx;
        if (err >= dy) begin
          if (!cell_open(cx + ox, cy + oy)) return 1'b0;
          cx  += sx;
          err -= dy;
        end
        if (err != 0 && !cell_open(cx + ox, cy + oy)) return 1'b0;
        if (dx == 0 && !cell_open(cx, cy + oy) && !cell_open(cx - 1, cy + oy)) return 1'b0;
        cy += sy;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t seen;
    answer_t want;
    answer_t fresh;
    if (!rst_ni) begin
      foreach (cell_map[i]) cell_map[i] = 1'b0;
      awaited_answers.delete();
      mismatches = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (pop && !empty) begin
        seen = answer_t'{line_clear: line_clear_i, was_query: was_query_i};
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result word, line_clear %0b was_query %0b",
                     $realtime, seen.line_clear, seen.was_query);
          end
        end else begin
          want = awaited_answers.pop_front();
          if (seen.line_clear !== want.line_clear || seen.was_query !== want.was_query) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: line_clear expected %0b got %0b, was_query expected %0b got %0b",
                       $realtime, want.line_clear, seen.line_clear,
                       want.was_query, seen.was_query);
            end
          end
        end
      end
      if (push && !full) begin
        if (func_i == glos_pkg::FUNC_WRITE) begin
          if (x_from_i < MapW && y_from_i < MapH) begin
            cell_map[int'(y_from_i) * MapW + int'(x_from_i)] = cell_free_i;
          end
          fresh = answer_t'{line_clear: 1'b0, was_query: 1'b0};
        end else begin
          fresh = answer_t'{
            line_clear: line_unblocked(int'(x_from_i), int'(y_from_i),
                                       int'(x_to_i), int'(y_to_i)),
            was_query:  1'b1};
        end
        awaited_answers.insert(awaited_answers.size(), fresh);
      end
      pending_o        <= awaited_answers.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

[tb/tb_grid_line_of_sight_check_top.sv]
`timescale 1ns / 1ps

module tb_grid_line_of_sight_check_top;

  localparam int          WordTarget = 1170;
  localparam int          HoldCycles = 2500;
  localparam int          TailCycles = 800;
  localparam int unsigned StallLimit = 300000;
  localparam int          SendSide   = 0;
  localparam int          TakeSide   = 1;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  logic        func      = glos_pkg::FUNC_WRITE;
  logic [7:0]  x_from    = '0;
  logic [7:0]  y_from    = '0;
  logic [7:0]  x_to      = '0;
  logic [7:0]  y_to      = '0;
  logic        cell_free = 1'b0;
  logic        empty;
  logic        pop       = 1'b0;
  logic        line_clear;
  logic        was_query;
  int unsigned mismatch_count;
  int unsigned pending;

  int calm_left [2];
  int words_sent;

  grid_line_of_sight_check_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func),
    .x_from_i     (x_from),
    .y_from_i     (y_from),
    .x_to_i       (x_to),
    .y_to_i       (y_to),
    .cell_free_i  (cell_free),
    .empty        (empty),
    .pop          (pop),
    .line_clear_o (line_clear),
    .was_query_o  (was_query)
  );

  glos_sight_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .func_i           (func),
    .x_from_i         (x_from),
    .y_from_i         (y_from),
    .x_to_i           (x_to),
    .y_to_i           (y_to),
    .cell_free_i      (cell_free),
    .empty            (empty),
    .pop              (pop),
    .line_clear_i     (line_clear),
    .was_query_i      (was_query),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Runs of back-to-back words are mixed in between random gaps.
  function automatic int draw_gap(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic int pick_origin(int span);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 256 - span;
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  task automatic offer_word(input logic fn, input int xf, input int yf,
                            input int xt, input int yt, input int cf);
    int gap;
    gap = draw_gap(SendSide);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func      <= fn;
    x_from    <= 8'(xf);
    y_from    <= 8'(yf);
    x_to      <= 8'(xt);
    y_to      <= 8'(yt);
    cell_free <= 1'(cf);
    push      <= 1'b1;
    do @(posedge clk_i); while (!(push && !full));
    words_sent++;
  endtask

  task automatic put_cell(input int x, input int y, input int free);
    offer_word(glos_pkg::FUNC_WRITE, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
               free);
  endtask

  task automatic ask_sight(input int xf, input int yf, input int xt, input int yt);
    offer_word(glos_pkg::FUNC_QUERY, xf, yf, xt, yt, $urandom_range(0, 1));
  endtask

  task automatic wait_all_answered();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // A scene frees most of a small window, then asks lines mostly inside it. Windows often
  // land near the origin so that free cells build up, or against a map edge.
  task automatic run_scene();
    int w, h, ox, oy, n, pick, ax, ay, bx, by;
    w  = $urandom_range(2, 8);
    h  = $urandom_range(2, 8);
    ox = pick_origin(w);
    oy = pick_origin(h);
    for (int y = oy; y < oy + h; y++) begin
      for (int x = ox; x < ox + w; x++) begin
        if ($urandom_range(0, 3) != 0) put_cell(x, y, ($urandom_range(0, 7) != 0) ? 1 : 0);
      end
    end
    n = $urandom_range(6, 16);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      ax   = ox + $urandom_range(0, w - 1);
      bx   = ox + $urandom_range(0, w - 1);
      ay   = oy + $urandom_range(0, h - 1);
      by   = oy + $urandom_range(0, h - 1);
      if (pick == 0) begin
        ask_sight($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick == 1) begin
        put_cell($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
      end else if (pick == 2) begin
        ask_sight($urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 31));
      end else if (pick <= 5) begin
        ask_sight(ax, ay, bx, ay);
      end else if (pick <= 8) begin
        ask_sight(ax, ay, ax, by);
      end else begin
        ask_sight(ax, ay, bx, by);
      end
    end
  endtask

  initial begin : result_taker
    int  gap;
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    wait (rst_ni);
    forever begin
      gap = draw_gap(TakeSide);
      // One long hold-off lets the block fill up and stall its input.
      if (!held && taken == 150) begin
        held = 1'b1;
        gap  = HoldCycles;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (!(pop && !empty));
      taken++;
    end
  end

  initial begin : stall_watch
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    words_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    ask_sight(5, 5, 5, 5);
    ask_sight(0, 0, 255, 255);
    ask_sight(255, 0, 0, 255);
    put_cell(0, 0, 1);
    put_cell(255, 255, 1);
    ask_sight(255, 255, 254, 254);
    put_cell(254, 254, 1);
    ask_sight(255, 255, 254, 254);
    put_cell(255, 255, 0);
    put_cell(1, 0, 1);
    put_cell(2, 0, 1);
    ask_sight(0, 0, 3, 0);
    ask_sight(3, 0, 0, 0);
    put_cell(0, 1, 1);
    put_cell(0, 2, 1);
    ask_sight(0, 0, 0, 3);
    ask_sight(0, 3, 0, 0);
    ask_sight(0, 0, 1, 1);
    ask_sight(0, 0, 255, 0);
    put_cell(0, 0, 0);
    ask_sight(0, 0, 1, 1);
    wait_all_answered();

    while (words_sent < WordTarget) run_scene();
    wait_all_answered();
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[grid_line_of_sight_check_top.f]
+incdir+rtl
rtl/glos_pkg.sv
rtl/glos_front.sv
rtl/glos_cmd_queue.sv
rtl/glos_walker.sv
rtl/grid_line_of_sight_check_top.sv
tb/glos_sight_checker.sv
tb/tb_grid_line_of_sight_check_top.sv
